/* src/frame_classify_queue_steer_assert.svh */
// Assertion macros shared by the frame classifier modules.
`ifndef FRAME_CLASSIFY_QUEUE_STEER_ASSERT_SVH
`define FRAME_CLASSIFY_QUEUE_STEER_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define FCQS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define FCQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/fcqs_pkg.sv */
// Types, constants and the socket lookup shared by the frame classifier.
`default_nettype none

package fcqs_pkg;

	localparam int SOCKET_SLOTS  = 64;
	localparam int MAX_VLAN_TAGS = 2;

	// Flow id remainder unit widths
	localparam int FLOW_W  = 32;
	localparam int QUEUE_W = 16;

	// Reason codes
	localparam logic [2:0] RS_TRUNC  = 3'd0;
	localparam logic [2:0] RS_ARP    = 3'd1;
	localparam logic [2:0] RS_ICMP   = 3'd2;
	localparam logic [2:0] RS_NONIP  = 3'd3;
	localparam logic [2:0] RS_REDIR  = 3'd4;
	localparam logic [2:0] RS_NOSOCK = 3'd5;

	// EtherTypes and protocol numbers
	localparam logic [15:0] ETYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
	localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
	localparam logic [15:0] ETYPE_CTAG  = 16'h8100;
	localparam logic [15:0] ETYPE_STAG  = 16'h88A8;
	localparam logic [7:0]  PROTO_ICMP4 = 8'd1;
	localparam logic [7:0]  PROTO_ICMP6 = 8'd58;

	// Register indexes (byte address / 8)
	localparam logic [1:0] REG_ENCAP  = 2'd0;
	localparam logic [1:0] REG_QCOUNT = 2'd1;
	localparam logic [1:0] REG_SOCKET = 2'd2;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [15:0] rx_queue;
	} fcqs_item_t;

	typedef struct packed {
		logic        verdict;
		logic [15:0] steer_queue;
		logic [2:0]  reason;
	} fcqs_result_t;

	// Try a redirect to queue q against the socket mask
	function automatic fcqs_result_t attempt(input logic [15:0] q, input logic [63:0] mask);
		fcqs_result_t r;
		logic ok;
		ok = (q < 16'(SOCKET_SLOTS)) && mask[q[5:0]];
		r.verdict     = ok;
		r.steer_queue = q;
		r.reason      = ok ? RS_REDIR : RS_NOSOCK;
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/frame_classify_queue_steer.sv */
// Frame classifier with VLAN stripping and flow-id queue steering (top level).
//
// Usage:
// - item channel (item_valid/item_stall/item) carries frame bytes in wire
//   order, one transfer per byte; item.last_byte marks the final byte, and
//   item.rx_queue is taken from that final byte.
// - result channel (result_valid/result_stall/result) gives one verdict per
//   frame: verdict, steer_queue and reason.
// - Configuration goes through the APB port: the encapsulation EtherType at
//   0x00, the flow queue count at 0x08, the socket mask at 0x10 (64-bit data).
// Timing:
// - One byte per cycle while item_stall is low. The result is registered and
//   appears the cycle after the last byte's transfer if no remainder starts.
// - On an encapsulated frame, once the 4-byte flow id completes and the queue
//   count is nonzero, the bit-serial remainder unit runs over the 32-bit flow
//   id, one dividend bit per cycle; item_stall is high while it runs. If the flow
//   id ends the frame, the result is registered once the remainder completes and the output is free.
// - While a result waits under result_stall, item_stall is high.
// Reset clears the configuration and parse state, drops any pending result
// and starts a fresh frame.
`default_nettype none
`include "frame_classify_queue_steer_assert.svh"

module frame_classify_queue_steer (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_stall,
	input  wire fcqs_pkg::fcqs_item_t   item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output fcqs_pkg::fcqs_result_t      result,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [4:0]             paddr,
	input  wire logic [63:0]            pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	// Parse phases
	localparam logic [2:0] PH_ETYPE = 3'd0;
	localparam logic [2:0] PH_FLOW  = 3'd1;
	localparam logic [2:0] PH_IP4   = 3'd2;
	localparam logic [2:0] PH_IP6   = 3'd3;
	localparam logic [2:0] PH_DONE  = 3'd4;
	localparam logic [2:0] PH_RXQ   = 3'd5;

	localparam logic [6:0] OFF_MAX = 7'd127;

	// Configuration registers
	logic [15:0] encap_q;
	logic [15:0] qc_q;
	logic [63:0] mask_q;

	// Per-frame parse state
	logic [6:0]  off_q;
	logic [15:0] ts_q;
	logic [1:0]  tag_q;
	logic [2:0]  ph_q;
	logic [31:0] flow_q;
	logic [2:0]  rsn_q;

	logic                   res_pend_q;
	logic                   out_valid_q;
	fcqs_pkg::fcqs_result_t out_q;

	// Next-state values for the current byte
	logic [6:0]  hs;
	logic [6:0]  ip_at;
	logic [6:0]  ip_end;
	logic [15:0] ts_n;
	logic [1:0]  tag_n;
	logic [2:0]  ph_n;
	logic [31:0] flow_n;
	logic [2:0]  rsn_n;
	logic        div_start;
	logic        vlan;
	logic        v4;

	logic                   item_acc;
	logic                   out_free;
	logic                   pend_fire;
	logic                   cfg_wr;
	fcqs_pkg::fcqs_result_t res_now;
	logic                   div_busy;
	logic                   div_done;
	logic [15:0]            div_rem;

	assign item_acc  = item_valid && !item_stall;
	assign out_free  = !out_valid_q || !result_stall;
	assign pend_fire = res_pend_q && !div_busy && out_free;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// Hold input during the remainder, a deferred result or a blocked output
	assign item_stall = div_busy || res_pend_q || (out_valid_q && result_stall);

	// Configuration write and readback
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encap_q <= '0;
			qc_q    <= '0;
			mask_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				fcqs_pkg::REG_ENCAP:  encap_q <= pwdata[15:0];
				fcqs_pkg::REG_QCOUNT: qc_q    <= pwdata[15:0];
				fcqs_pkg::REG_SOCKET: mask_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			fcqs_pkg::REG_ENCAP:  prdata = {48'd0, encap_q};
			fcqs_pkg::REG_QCOUNT: prdata = {48'd0, qc_q};
			fcqs_pkg::REG_SOCKET: prdata = mask_q;
			default:              prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Header positions relative to the tag count
	assign hs     = 7'd14 + {3'd0, tag_q, 2'b00};
	assign v4     = (ph_q == PH_IP4);
	assign ip_at  = hs + (v4 ? 7'd9 : 7'd6);
	assign ip_end = hs + (v4 ? 7'd19 : 7'd39);

	// Advance the parse by one byte
	always_comb begin
		ts_n      = ts_q;
		tag_n     = tag_q;
		ph_n      = ph_q;
		flow_n    = flow_q;
		rsn_n     = rsn_q;
		div_start = 1'b0;
		vlan      = 1'b0;
		unique case (ph_q)
			PH_ETYPE: begin
				ts_n = {ts_q[7:0], item.data_byte};
				if (off_q == hs - 7'd1) begin
					vlan = (ts_n == fcqs_pkg::ETYPE_CTAG) || (ts_n == fcqs_pkg::ETYPE_STAG);
					if (vlan && ({30'd0, tag_q} < 32'(fcqs_pkg::MAX_VLAN_TAGS))) begin
						tag_n = tag_q + 2'd1;
					end else if (ts_n == fcqs_pkg::ETYPE_ARP) begin
						ph_n  = PH_DONE;
						rsn_n = fcqs_pkg::RS_ARP;
					end else if (encap_q != 16'd0 && ts_n == encap_q) begin
						ph_n   = PH_FLOW;
						flow_n = '0;
					end else if (ts_n == fcqs_pkg::ETYPE_IPV4) begin
						ph_n  = PH_IP4;
						rsn_n = fcqs_pkg::RS_REDIR;
					end else if (ts_n == fcqs_pkg::ETYPE_IPV6) begin
						ph_n  = PH_IP6;
						rsn_n = fcqs_pkg::RS_REDIR;
					end else begin
						ph_n  = PH_DONE;
						rsn_n = fcqs_pkg::RS_NONIP;
					end
				end
			end
			PH_FLOW: begin
				if (off_q >= hs && off_q <= hs + 7'd3) begin
					flow_n = {flow_q[23:0], item.data_byte};
				end
				if (off_q == hs + 7'd3) begin
					if (qc_q != 16'd0) begin
						ph_n      = PH_DONE;
						rsn_n     = fcqs_pkg::RS_REDIR;
						div_start = 1'b1;
					end else begin
						ph_n = PH_RXQ;
					end
				end
			end
			PH_IP4, PH_IP6: begin
				if (off_q == ip_at &&
				    item.data_byte == (v4 ? fcqs_pkg::PROTO_ICMP4 : fcqs_pkg::PROTO_ICMP6)) begin
					rsn_n = fcqs_pkg::RS_ICMP;
				end
				if (off_q == ip_end) begin
					ph_n = (rsn_n == fcqs_pkg::RS_ICMP) ? PH_DONE : PH_RXQ;
				end
			end
			default: ;
		endcase
	end

	// Verdict for a frame ending on this byte
	always_comb begin
		res_now = '0;
		priority if (ph_n == PH_FLOW || ph_n == PH_RXQ) begin
			res_now = fcqs_pkg::attempt(item.rx_queue, mask_q);
		end else if (ph_n == PH_DONE && rsn_n == fcqs_pkg::RS_REDIR) begin
			res_now = fcqs_pkg::attempt(div_rem, mask_q);
		end else if (ph_n == PH_DONE) begin
			res_now.reason = rsn_n;
		end else begin
			res_now.reason = fcqs_pkg::RS_TRUNC;
		end
	end

	// Parse state: advance per byte, clear after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			ts_q   <= '0;
			tag_q  <= '0;
			ph_q   <= PH_ETYPE;
			flow_q <= '0;
			rsn_q  <= fcqs_pkg::RS_TRUNC;
		end else if (item_acc) begin
			if (item.last_byte) begin
				off_q  <= '0;
				ts_q   <= '0;
				tag_q  <= '0;
				ph_q   <= PH_ETYPE;
				flow_q <= '0;
				rsn_q  <= fcqs_pkg::RS_TRUNC;
			end else begin
				off_q  <= (off_q != OFF_MAX) ? off_q + 7'd1 : off_q;
				ts_q   <= ts_n;
				tag_q  <= tag_n;
				ph_q   <= ph_n;
				flow_q <= flow_n;
				rsn_q  <= rsn_n;
			end
		end
	end

	// Output register and deferred result after the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_pend_q  <= 1'b0;
		end else begin
			if (item_acc && item.last_byte && !div_start) begin
				out_valid_q <= 1'b1;
			end else if (pend_fire) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (item_acc && item.last_byte && div_start) begin
				res_pend_q <= 1'b1;
			end else if (pend_fire) begin
				res_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && item.last_byte && !div_start) begin
			out_q <= res_now;
		end else if (pend_fire) begin
			out_q <= fcqs_pkg::attempt(div_rem, mask_q);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	fcqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (item_acc && div_start),
		.dividend (flow_n),
		.divisor  (qc_q),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem)
	);

	`FCQS_ASSERT_IMP(a_no_byte_in_div, item_acc, !div_busy && !res_pend_q, "byte taken during remainder")
	`FCQS_ASSERT_IMP(a_pend_has_div, $rose(res_pend_q), div_busy, "deferred result without remainder run")
	`FCQS_ASSERT_IMP(a_redir_reason, out_valid_q && out_q.verdict, out_q.reason == fcqs_pkg::RS_REDIR, "redirect with wrong reason")
	`FCQS_ASSERT_IMP(a_pass_queue, out_valid_q && !out_q.verdict && out_q.reason != fcqs_pkg::RS_NOSOCK, out_q.steer_queue == 16'd0, "pass verdict with a queue")
	`FCQS_ASSERT_IMP(a_div_done_pend, div_done && res_pend_q, !div_busy, "remainder busy at completion")

endmodule

`default_nettype wire

/* src/fcqs_div.sv */
// Bit-serial restoring remainder unit: flow id modulo queue count.
`default_nettype none
`include "frame_classify_queue_steer_assert.svh"

module fcqs_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [fcqs_pkg::FLOW_W-1:0]    dividend,
	input  wire logic [fcqs_pkg::QUEUE_W-1:0]   divisor,
	output logic                                busy,
	output logic                                done,
	output logic [fcqs_pkg::QUEUE_W-1:0]        rem
);

	localparam int CNT_W = $clog2(fcqs_pkg::FLOW_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fcqs_pkg::FLOW_W - 1);

	logic [fcqs_pkg::FLOW_W-1:0]  dvd_q;
	logic [fcqs_pkg::QUEUE_W-1:0] dvs_q;
	logic [fcqs_pkg::QUEUE_W-1:0] rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [fcqs_pkg::QUEUE_W:0]   trial;
	logic [fcqs_pkg::QUEUE_W-1:0] rem_nxt;

	// Bring down one dividend bit and subtract the divisor if it fits
	always_comb begin
		trial = {rem_q, dvd_q[fcqs_pkg::FLOW_W-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = fcqs_pkg::QUEUE_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[fcqs_pkg::QUEUE_W-1:0];
		end
	end

	// Control: load on start, count one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, update partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[fcqs_pkg::FLOW_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rem  = rem_q;

	`FCQS_ASSERT_IMP(a_no_restart, start, !busy_q, "remainder unit restarted while busy")
	`FCQS_ASSERT_NEXT(a_finish, busy_q && !start && cnt_q == CNT_LAST, done_q && !busy_q, "remainder unit did not finish")
	`FCQS_ASSERT_IMP(a_rem_range, done_q, rem_q < dvs_q, "remainder not below divisor")

endmodule

`default_nettype wire
